[rtl/sps_pkg.sv]
// Package for the shoulder pivot reach scaler: payload structs, register
// indexes, reset values, arithmetic widths and saturation helpers.
// No dependencies.
`default_nettype none
package sps_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_EXT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHZ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MINR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EN = 3'd7;

    localparam logic        [15:0] RST_EXT    = 16'd5325;
    localparam logic signed [15:0] RST_SHX    = 16'sd184;
    localparam logic signed [15:0] RST_SHY    = -16'sd205;
    localparam logic signed [15:0] RST_SHZ    = 16'sd82;
    localparam logic        [15:0] RST_SMOOTH = 16'd1638;
    localparam logic        [14:0] RST_MINR   = 15'd102;

    localparam logic [16:0] ALPHA_ONE = 17'd32768;
    localparam logic [16:0] ALPHA_MIN = 17'd328;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    typedef struct packed {
        logic        hand_is_right;
        logic        poses_valid;
        logic [47:0] head_rot_row0;
        logic [47:0] head_rot_row1;
        logic [47:0] head_rot_row2;
        logic [47:0] head_position;
        logic [47:0] hand_position;
        logic [47:0] hand_velocity;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_pos_x;
        logic signed [15:0] out_pos_y;
        logic signed [15:0] out_pos_z;
        logic signed [15:0] out_vel_x;
        logic signed [15:0] out_vel_y;
        logic signed [15:0] out_vel_z;
        logic               modified;
    } t_out;

    typedef struct packed {
        logic en;
        logic acc_add;
    } t_mac_ctl;

    function automatic logic signed [23:0] f_sat24(input logic signed [27:0] x);
        logic signed [23:0] y;
        if (x > 28'sd8388607) begin
            y = 24'sd8388607;
        end else if (x < -28'sd8388608) begin
            y = -24'sd8388608;
        end else begin
            y = x[23:0];
        end
        return y;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [27:0] x);
        logic signed [15:0] y;
        if (x > 28'sd32767) begin
            y = 16'sd32767;
        end else if (x < -28'sd32768) begin
            y = -16'sd32768;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

[rtl/sps_mac.sv]
// Shared multiply-accumulate unit: registered signed product, then a
// registered accumulator that either loads or adds the product.
// Depends on sps_pkg.
`default_nettype none
module sps_mac (
    input  wire logic                                i_clk,
    input  wire sps_pkg::t_mac_ctl                   i_ctl,
    input  wire logic signed [sps_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [sps_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [sps_pkg::ACC_W-1:0]         o_acc
);

    logic signed [sps_pkg::PROD_W-1:0] r_prod;
    logic signed [sps_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= i_a * i_b;
            if (i_ctl.acc_add) begin
                r_acc <= r_acc + sps_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= sps_pkg::ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

[rtl/shoulder_pivot_reach_scaler.sv]
// Shoulder pivot reach scaler top level: config registers, sequencer,
// smoother state and output register around the shared MAC.
// Depends on sps_pkg and sps_mac.
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+---------------------------
//  input     | i_valid      | o_ready      | i_data  (sps_pkg::t_in)
//  output    | o_valid      | i_ready      | o_data  (sps_pkg::t_out)
//  config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An extended sample runs 24 MAC steps through the single 25x21 multiplier,
// then passes the done state, which waits for the output register, and the
// idle state before the next input transfer.
// A disabled hand or invalid pose skips the MAC steps; a short arm aborts them unmodified.
// Reset clears the state machine and smoother primed bits and loads the config defaults.
// A waiting result sits in the output register while the next sample enters;
// a finished sample holds until that register frees.
`default_nettype none
module shoulder_pivot_reach_scaler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire sps_pkg::t_in                   i_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sps_pkg::t_out                       o_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [4:0] SQ_ROT  = 5'd0;
    localparam logic [4:0] SQ_SQR  = 5'd9;
    localparam logic [4:0] SQ_MINR = 5'd12;
    localparam logic [4:0] SQ_TGT  = 5'd13;
    localparam logic [4:0] SQ_SMO  = 5'd16;
    localparam logic [4:0] SQ_VEL  = 5'd19;
    localparam logic [4:0] SQ_LAST = 5'd23;

    localparam int AW = sps_pkg::MUL_A_W;
    localparam int BW = sps_pkg::MUL_B_W;
    localparam int CW = sps_pkg::ACC_W;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic        r_ovalid, n_ovalid;

    logic        [15:0] r_ext;
    logic signed [15:0] r_shx, r_shy, r_shz;
    logic        [15:0] r_smooth;
    logic        [14:0] r_minr;
    logic               r_left_en, r_right_en;

    sps_pkg::t_in       r_in;
    sps_pkg::t_out      r_res;
    sps_pkg::t_out      r_out;
    logic signed [19:0] r_shd [3];
    logic signed [20:0] r_arm [3];
    logic        [42:0] r_len2;
    logic signed [23:0] r_tgt [3];
    logic signed [23:0] r_sv  [3];
    logic signed [23:0] r_sm  [2][3];
    logic [1:0]         r_primed;

    logic signed [15:0] w_rot  [3][3];
    logic signed [15:0] w_head [3];
    logic signed [15:0] w_pos  [3];
    logic signed [15:0] w_vel  [3];
    logic signed [16:0] w_loc  [3];
    logic signed [23:0] w_scur [3];
    logic signed [23:0] w_snew [3];
    logic        [16:0] w_alpha;
    logic signed [AW-1:0] w_a;
    logic signed [BW-1:0] w_b;
    logic signed [BW-1:0] w_extb;
    logic signed [CW-1:0] w_acc;
    logic signed [CW-1:0] w_rnd12, w_rnd14, w_rnd15;
    logic [1:0]         w_row;
    logic signed [19:0] w_shd_new;
    logic signed [20:0] w_arm_new;
    logic               w_short;
    logic               w_hand;
    logic               w_in_xfer;
    logic               w_in_enabled;
    logic               w_load_out;
    sps_pkg::t_mac_ctl  w_ctl;

    assign w_hand      = r_in.hand_is_right;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_valid && o_ready;
    assign w_in_enabled = i_data.hand_is_right ? r_right_en : r_left_en;
    assign w_load_out  = (r_state == ST_DONE) && (!r_ovalid || i_ready);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rot[0][k] = r_in.head_rot_row0[16*k +: 16];
            w_rot[1][k] = r_in.head_rot_row1[16*k +: 16];
            w_rot[2][k] = r_in.head_rot_row2[16*k +: 16];
            w_head[k]   = r_in.head_position[16*k +: 16];
            w_pos[k]    = r_in.hand_position[16*k +: 16];
            w_vel[k]    = r_in.hand_velocity[16*k +: 16];
        end
    end

    always_comb begin
        w_loc[0] = w_hand ? 17'(r_shx) : -17'(r_shx);
        w_loc[1] = 17'(r_shy);
        w_loc[2] = 17'(r_shz);
        if (r_smooth > 16'(sps_pkg::ALPHA_ONE - sps_pkg::ALPHA_MIN)) begin
            w_alpha = sps_pkg::ALPHA_MIN;
        end else begin
            w_alpha = sps_pkg::ALPHA_ONE - 17'(r_smooth);
        end
        w_extb = BW'({1'b0, r_ext});
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_scur[k] = r_primed[w_hand] ? r_sm[w_hand][k] : r_tgt[k];
            w_snew[k] = sps_pkg::f_sat24(28'(r_sv[k]) + $signed(w_rnd15[27:0]));
        end
    end

    // operand select for the product issued this step
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_row = 2'd0;
        case (r_step)
            SQ_ROT:        begin w_a = AW'(w_rot[0][0]); w_b = BW'(w_loc[0]); end
            SQ_ROT + 5'd1: begin w_a = AW'(w_rot[0][1]); w_b = BW'(w_loc[1]); end
            SQ_ROT + 5'd2: begin w_a = AW'(w_rot[0][2]); w_b = BW'(w_loc[2]); end
            SQ_ROT + 5'd3: begin w_a = AW'(w_rot[1][0]); w_b = BW'(w_loc[0]); end
            SQ_ROT + 5'd4: begin
                w_a = AW'(w_rot[1][1]); w_b = BW'(w_loc[1]); w_row = 2'd0;
            end
            SQ_ROT + 5'd5: begin w_a = AW'(w_rot[1][2]); w_b = BW'(w_loc[2]); end
            SQ_ROT + 5'd6: begin w_a = AW'(w_rot[2][0]); w_b = BW'(w_loc[0]); end
            SQ_ROT + 5'd7: begin
                w_a = AW'(w_rot[2][1]); w_b = BW'(w_loc[1]); w_row = 2'd1;
            end
            SQ_ROT + 5'd8: begin w_a = AW'(w_rot[2][2]); w_b = BW'(w_loc[2]); end
            SQ_SQR:        begin w_a = AW'(r_arm[0]); w_b = BW'(r_arm[0]); end
            SQ_SQR + 5'd1: begin
                w_a = AW'(r_arm[1]); w_b = BW'(r_arm[1]); w_row = 2'd2;
            end
            SQ_SQR + 5'd2: begin w_a = AW'(r_arm[2]); w_b = BW'(r_arm[2]); end
            SQ_MINR:       begin w_a = AW'({1'b0, r_minr}); w_b = BW'({1'b0, r_minr}); end
            SQ_TGT:        begin w_a = AW'(r_arm[0]); w_b = w_extb; end
            SQ_TGT + 5'd1: begin w_a = AW'(r_arm[1]); w_b = w_extb; end
            SQ_TGT + 5'd2: begin w_a = AW'(r_arm[2]); w_b = w_extb; end
            SQ_SMO:        begin
                w_a = AW'(r_tgt[0]) - AW'(w_scur[0]); w_b = BW'(w_alpha);
            end
            SQ_SMO + 5'd1: begin
                w_a = AW'(r_tgt[1]) - AW'(w_scur[1]); w_b = BW'(w_alpha);
            end
            SQ_SMO + 5'd2: begin
                w_a = AW'(r_tgt[2]) - AW'(w_scur[2]); w_b = BW'(w_alpha);
            end
            SQ_VEL:        begin w_a = AW'(w_vel[0]); w_b = w_extb; end
            SQ_VEL + 5'd1: begin w_a = AW'(w_vel[1]); w_b = w_extb; end
            SQ_VEL + 5'd2: begin w_a = AW'(w_vel[2]); w_b = w_extb; end
            default:       begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_ctl.en      = (r_state == ST_RUN);
    assign w_ctl.acc_add = r_step inside {5'd2, 5'd3, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12};

    sps_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    assign w_rnd12 = (w_acc + 47'sd2048) >>> 12;
    assign w_rnd14 = (w_acc + 47'sd8192) >>> 14;
    assign w_rnd15 = (w_acc + 47'sd16384) >>> 15;
    assign w_shd_new = 20'(28'(w_head[w_row]) + $signed(w_rnd14[27:0]));
    assign w_arm_new = 21'(w_pos[w_row]) - 21'(w_shd_new);
    assign w_short   = r_len2 < w_acc[42:0];

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_step = SQ_ROT;
                    if (w_in_enabled && i_data.poses_valid) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                if ((r_step == SQ_TGT + 5'd1) && w_short) begin
                    n_state = ST_DONE;
                end else if (r_step == SQ_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SQ_ROT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext      <= sps_pkg::RST_EXT;
            r_shx      <= sps_pkg::RST_SHX;
            r_shy      <= sps_pkg::RST_SHY;
            r_shz      <= sps_pkg::RST_SHZ;
            r_smooth   <= sps_pkg::RST_SMOOTH;
            r_minr     <= sps_pkg::RST_MINR;
            r_left_en  <= 1'b1;
            r_right_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sps_pkg::CFG_EXT:      r_ext      <= i_cfg_data;
                sps_pkg::CFG_SHX:      r_shx      <= i_cfg_data;
                sps_pkg::CFG_SHY:      r_shy      <= i_cfg_data;
                sps_pkg::CFG_SHZ:      r_shz      <= i_cfg_data;
                sps_pkg::CFG_SMOOTH:   r_smooth   <= i_cfg_data;
                sps_pkg::CFG_MINR:     r_minr     <= i_cfg_data[14:0];
                sps_pkg::CFG_LEFT_EN:  r_left_en  <= i_cfg_data[0];
                sps_pkg::CFG_RIGHT_EN: r_right_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 2'b00;
        end else if (w_in_xfer) begin
            if (w_in_enabled && !i_data.poses_valid) begin
                r_primed[i_data.hand_is_right] <= 1'b0;
            end
        end else if (r_state == ST_RUN) begin
            if ((r_step == SQ_TGT + 5'd1) && w_short) begin
                r_primed[w_hand] <= 1'b0;
            end else if (r_step == SQ_SMO + 5'd4) begin
                r_primed[w_hand] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
        if (w_in_xfer) begin
            r_in              <= i_data;
            r_res.out_pos_x   <= i_data.hand_position[15:0];
            r_res.out_pos_y   <= i_data.hand_position[31:16];
            r_res.out_pos_z   <= i_data.hand_position[47:32];
            r_res.out_vel_x   <= i_data.hand_velocity[15:0];
            r_res.out_vel_y   <= i_data.hand_velocity[31:16];
            r_res.out_vel_z   <= i_data.hand_velocity[47:32];
            r_res.modified    <= 1'b0;
        end else if (r_state == ST_RUN) begin
            case (r_step)
                SQ_ROT + 5'd4: begin
                    r_shd[0] <= w_shd_new;
                    r_arm[0] <= w_arm_new;
                end
                SQ_ROT + 5'd7: begin
                    r_shd[1] <= w_shd_new;
                    r_arm[1] <= w_arm_new;
                end
                SQ_SQR + 5'd1: begin
                    r_shd[2] <= w_shd_new;
                    r_arm[2] <= w_arm_new;
                end
                SQ_TGT: begin
                    r_len2 <= w_acc[42:0];
                end
                SQ_TGT + 5'd2: begin
                    r_tgt[0] <= sps_pkg::f_sat24(28'(r_shd[0]) + $signed(w_rnd12[27:0]));
                end
                SQ_SMO: begin
                    r_tgt[1] <= sps_pkg::f_sat24(28'(r_shd[1]) + $signed(w_rnd12[27:0]));
                    r_sv[0]  <= w_scur[0];
                end
                SQ_SMO + 5'd1: begin
                    r_tgt[2] <= sps_pkg::f_sat24(28'(r_shd[2]) + $signed(w_rnd12[27:0]));
                    r_sv[1]  <= w_scur[1];
                end
                SQ_SMO + 5'd2: begin
                    r_sv[2]         <= w_scur[2];
                    r_sm[w_hand][0] <= w_snew[0];
                    r_res.out_pos_x <= sps_pkg::f_sat16(28'(w_snew[0]));
                end
                SQ_SMO + 5'd3: begin
                    r_sm[w_hand][1] <= w_snew[1];
                    r_res.out_pos_y <= sps_pkg::f_sat16(28'(w_snew[1]));
                end
                SQ_SMO + 5'd4: begin
                    r_sm[w_hand][2] <= w_snew[2];
                    r_res.out_pos_z <= sps_pkg::f_sat16(28'(w_snew[2]));
                end
                SQ_VEL + 5'd2: begin
                    r_res.out_vel_x <= sps_pkg::f_sat16($signed(w_rnd12[27:0]));
                end
                SQ_VEL + 5'd3: begin
                    r_res.out_vel_y <= sps_pkg::f_sat16($signed(w_rnd12[27:0]));
                end
                SQ_LAST: begin
                    r_res.out_vel_z <= sps_pkg::f_sat16($signed(w_rnd12[27:0]));
                    r_res.modified  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_step <= SQ_LAST))
        else $error("sequencer step beyond last step");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after a transfer");

    a_primed_after_smooth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == SQ_SMO + 5'd4) |=> r_primed[r_in.hand_is_right])
        else $error("smoother not primed after update");

    a_short_arm_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == SQ_TGT + 5'd1 && w_short)
        |=> (r_state == ST_DONE && !r_res.modified))
        else $error("short arm did not pass through");
`endif

endmodule
`default_nettype wire
